@@ design/lpht_pkg.sv @@
// Package for the linear probing hash table: sizes, field widths and codes.
// No dependencies; lpht_if and the top level import it.
package lpht_pkg;

   localparam int SLOTS    = 1024;
   localparam int KEY_BITS = 64;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int SIZE_W = IDX_W + 1;
   localparam int KEY_W  = 64;
   localparam int HASH_W = 64;
   localparam int CFG_W  = 11;
   localparam int PCNT_W = 11;
   localparam int SLOT_W = 10;
   localparam int STAT_W = 2;
   localparam int BCNT_W = $clog2(HASH_W);
   localparam int ENTRY_W = KEY_BITS + 1;

   localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = CFG_W'(1024);

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_MISS = 2'd2;

endpackage

@@ design/lpht_if.sv @@
// Channel interfaces for the hash table: request, response and CSR write.
// Depends on lpht_pkg.
interface lpht_req_if import lpht_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              req_type;
   logic [KEY_W-1:0]  key;
   logic [HASH_W-1:0] hash;

   modport source (output valid, req_type, key, hash, input ready);
   modport sink   (input valid, req_type, key, hash, output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PCNT_W-1:0] probe_count;
   logic [SLOT_W-1:0] slot_index;
   logic [STAT_W-1:0] status;

   modport source (output valid, probe_count, slot_index, status, input ready);
   modport sink   (input valid, probe_count, slot_index, status, output ready);
endinterface

interface lpht_csr_if import lpht_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

@@ design/lpht_ram.sv @@
// Generic single-port RAM with registered read data.
// No dependencies.
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ design/linear_probe_hash_table.sv @@
// Top level of the open-addressing hash table with linear probing.
// Depends on lpht_pkg, the channel interfaces in lpht_if and lpht_ram.
//
//   channel   ports      direction  payload
//   request   req_bus    in         req_type, key, hash
//   response  rsp_bus    out        probe_count, slot_index, status
//   csr       csr_bus    in         data (table_size), always ready
//
// After reset a clearing pass writes every slot empty (SLOTS, 1024 slots)
// while no request is taken. One request at a time: a bit-serial modulo
// over the HASH_W (64) hash bits, then per probed slot a RAM read, then a
// check and write back, and last a hand-over of the result to the output
// register. The next request is taken while a response still waits in
// rsp_bus.
module linear_probe_hash_table import lpht_pkg::*; (
   input  logic clock,
   input  logic reset,
   lpht_req_if.sink   req_bus,
   lpht_rsp_if.source rsp_bus,
   lpht_csr_if.sink   csr_bus
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MOD   = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_REPLY = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CFG_W-1:0]    size_ff, size_in;
   logic [IDX_W-1:0]    clear_cnt_ff, clear_cnt_in;
   logic [BCNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                lookup_ff, lookup_in;
   logic [SIZE_W-1:0]   n_ff, n_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic [SIZE_W-1:0]   steps_ff, steps_in;
   logic [PCNT_W-1:0]   res_pcnt_ff, res_pcnt_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [STAT_W-1:0]   res_stat_ff, res_stat_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PCNT_W-1:0]   rsp_pcnt_ff, rsp_pcnt_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STAT_W-1:0]   rsp_stat_ff, rsp_stat_in;

   logic                req_xfer;
   logic [SIZE_W-1:0]   n_eff;
   logic [SIZE_W-1:0]   shifted;
   logic [SIZE_W-1:0]   pos_inc;
   logic [IDX_W-1:0]    ram_addr;
   logic                ram_we;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;

   lpht_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.probe_count = rsp_pcnt_ff;
   assign rsp_bus.slot_index  = rsp_slot_ff;
   assign rsp_bus.status      = rsp_stat_ff;

   // Zero acts as one, anything above the slot count saturates.
   always_comb begin
      if (size_ff == '0) begin
         n_eff = SIZE_W'(1);
      end else if (size_ff > CFG_W'(SLOTS)) begin
         n_eff = SIZE_W'(SLOTS);
      end else begin
         n_eff = SIZE_W'(size_ff);
      end
   end

   assign shifted = {rem_ff[SIZE_W-2:0], hash_ff[HASH_W-1]};
   assign pos_inc = {1'b0, pos_ff} + SIZE_W'(1);

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      clear_cnt_in = clear_cnt_ff;
      bit_cnt_in   = bit_cnt_ff;
      hash_in      = hash_ff;
      key_in       = key_ff;
      lookup_in    = lookup_ff;
      n_in         = n_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      steps_in     = steps_ff;
      res_pcnt_in  = res_pcnt_ff;
      res_slot_in  = res_slot_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pcnt_in  = rsp_pcnt_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_stat_in  = rsp_stat_ff;
      ram_addr     = pos_ff;
      ram_we       = 1'b0;
      ram_wdata    = {1'b1, key_ff};

      if (csr_bus.valid && csr_bus.ready) begin
         size_in = csr_bus.data;
      end

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_addr  = clear_cnt_ff;
            ram_we    = 1'b1;
            ram_wdata = '0;
            clear_cnt_in = clear_cnt_ff + IDX_W'(1);
            if (clear_cnt_ff == IDX_W'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               lookup_in  = (req_bus.req_type == REQ_LOOKUP);
               key_in     = req_bus.key[KEY_BITS-1:0];
               hash_in    = req_bus.hash;
               n_in       = n_eff;
               rem_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_MOD;
            end
         end
         ST_MOD: begin
            // Restoring division, one hash bit per cycle, MSB first.
            if (shifted >= n_ff) begin
               rem_in = shifted - n_ff;
            end else begin
               rem_in = shifted;
            end
            hash_in    = {hash_ff[HASH_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BCNT_W'(1);
            if (bit_cnt_ff == BCNT_W'(HASH_W - 1)) begin
               pos_in   = rem_in[IDX_W-1:0];
               steps_in = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (steps_ff >= n_ff) begin
               res_pcnt_in = PCNT_W'(steps_ff);
               res_slot_in = '0;
               res_stat_in = lookup_ff ? STATUS_MISS : STATUS_FULL;
               state_in    = ST_REPLY;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_pcnt_in = PCNT_W'(steps_ff);
            if (!ram_rdata[KEY_BITS]) begin
               if (lookup_ff) begin
                  res_slot_in = '0;
                  res_stat_in = STATUS_MISS;
               end else begin
                  ram_we      = 1'b1;
                  res_slot_in = SLOT_W'(pos_ff);
                  res_stat_in = STATUS_DONE;
               end
               state_in = ST_REPLY;
            end else if (lookup_ff && (ram_rdata[KEY_BITS-1:0] == key_ff)) begin
               res_slot_in = SLOT_W'(pos_ff);
               res_stat_in = STATUS_DONE;
               state_in    = ST_REPLY;
            end else begin
               // Advance to the next slot, wrap at the table size.
               steps_in = steps_ff + SIZE_W'(1);
               pos_in   = (pos_inc >= n_ff) ? '0 : pos_inc[IDX_W-1:0];
               state_in = ST_PROBE;
            end
         end
         ST_REPLY: begin
            // Hold until the output register is free or drains this cycle.
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_pcnt_in  = res_pcnt_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         size_ff      <= TABLE_SIZE_RESET;
         clear_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         clear_cnt_ff <= clear_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      hash_ff     <= hash_in;
      key_ff      <= key_in;
      lookup_ff   <= lookup_in;
      n_ff        <= n_in;
      rem_ff      <= rem_in;
      pos_ff      <= pos_in;
      steps_ff    <= steps_in;
      res_pcnt_ff <= res_pcnt_in;
      res_slot_ff <= res_slot_in;
      res_stat_ff <= res_stat_in;
      rsp_pcnt_ff <= rsp_pcnt_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPLY))
      else $error("response raised without a finished request");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR) || (state_ff == ST_CHECK && !lookup_ff))
      else $error("slot write outside clear or insert");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> ({1'b0, pos_ff} < n_ff))
      else $error("probe position beyond table size");

   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |=> (steps_ff <= n_ff))
      else $error("probe count ran past table size");

   a_check_after_probe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> $past(state_ff == ST_PROBE))
      else $error("slot check without a read the cycle before");

endmodule
